@@ rtl/rdsm_pkg.sv @@
// Shared types, symbol codes and helpers for the dot-star pattern matcher.
// No dependencies; the top level, the pattern store and the match column import it.
`default_nettype none

package rdsm_pkg;

  // Item commands
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TEXT    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_LEAD_STAR = 2'd2
  } status_t;

  // Pattern metacharacters
  localparam logic [7:0] SYM_ANY  = 8'h2E;
  localparam logic [7:0] SYM_STAR = 8'h2A;

  // Fixed field widths
  localparam int unsigned SYM_W = 8;
  localparam int unsigned LEN_W = 6;

  // Status flags from the pattern store after one update
  typedef struct packed {
    logic dropped;    // append hit a full store
    logic lead_star;  // pattern begins with a star after the update
  } pat_flags_t;

  // Element compare: '.' takes any byte
  function automatic logic elem_hits(input logic [7:0] elem, input logic [7:0] sym);
    return (elem == SYM_ANY) || (elem == sym);
  endfunction

endpackage

`default_nettype wire

@@ rtl/rdsm_item_if.sv @@
// Input channel of the matcher: command and symbol with valid/ready handshake.
// Depends on nothing; the top level takes it through the sink modport.
`default_nettype none

interface rdsm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

`default_nettype wire

@@ rtl/rdsm_result_if.sv @@
// Result channel of the matcher: match flag, status and pattern length.
// Depends on nothing; the top level drives it through the source modport.
`default_nettype none

interface rdsm_result_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] status;
  logic [5:0] pattern_length;

  modport source (output valid, output matched, output status, output pattern_length,
                  input ready);
  modport sink   (input valid, input matched, input status, input pattern_length,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/regex_dot_star_matcher.sv @@
// Top level of the dot-star pattern matcher: input register, pattern store,
// match column and result register. Depends on rdsm_pkg, rdsm_item_if,
// rdsm_result_if, rdsm_pattern_store and rdsm_match_column.
//
// Usage:
//   items   : command (clear, append pattern byte, restart text, text byte)
//             and symbol. Append bytes to build the pattern ('.' any byte,
//             'x*' zero or more x), then stream text bytes.
//   results : one transaction per item: matched (whole text so far matches
//             the whole pattern), status (ok, byte dropped on a full store,
//             pattern begins with a star) and pattern_length.
// Result valid rises once the item has passed the input register and the
// result register. One item is taken every cycle while the result side does
// not stall: the column update is one parallel-prefix pass over the pattern,
// done between the input register and the result register.
// Reset empties the pattern and leaves the column at the empty-text state.
// When the result side stalls, the input register still takes one more item;
// items then wait until the result register drains.
`default_nettype none

module regex_dot_star_matcher
  import rdsm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  rdsm_item_if.sink       items,
  rdsm_result_if.source   results
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

  logic                              s1_valid;
  cmd_t                              s1_cmd;
  logic [SYM_W-1:0]                  s1_sym;
  logic                              advance;
  logic                              fire;
  logic [MAX_PATTERN-1:0][SYM_W-1:0] pattern;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  logic [MAX_PATTERN:0]              empty_next;
  logic [MAX_PATTERN:0]              col_next;
  pat_flags_t                        flags;
  status_t                           status_next;
  logic                              matched_next;
  logic [CW+LEN_W-1:0]               count_ext;

  assign advance     = !results.valid || results.ready;
  assign fire        = s1_valid && advance;
  assign items.ready = !s1_valid || advance;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cmd <= CMD_RESTART;
    end else if (items.ready && items.valid) begin
      s1_cmd <= cmd_t'(items.command);
      s1_sym <= items.symbol;
    end
  end

  rdsm_pattern_store #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (s1_cmd),
    .sym        (s1_sym),
    .pattern    (pattern),
    .count      (count),
    .count_next (count_next),
    .empty_next (empty_next),
    .flags      (flags)
  );

  rdsm_match_column #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_column (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (s1_cmd),
    .sym        (s1_sym),
    .pattern    (pattern),
    .count      (count),
    .empty_next (empty_next),
    .col_next   (col_next)
  );

  // Form the result from the updated state
  always_comb begin
    priority if (flags.dropped) begin
      status_next = ST_FULL;
    end else if (flags.lead_star) begin
      status_next = ST_LEAD_STAR;
    end else begin
      status_next = ST_OK;
    end
  end

  assign matched_next = !flags.lead_star && col_next[count_next];
  assign count_ext    = {{LEN_W{1'b0}}, count_next};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.matched        <= matched_next;
      results.status         <= status_next;
      results.pattern_length <= count_ext[LEN_W-1:0];
    end
  end

  // The count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PATTERN))
    else $error("pattern count beyond store depth");

  // Column bits above the pattern length stay clear
  a_column_clean: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((col_next >> count_next) <= (MAX_PATTERN+1)'(1)))
    else $error("match column has bits beyond pattern length");

  // A pattern that begins with a star never reports a match
  a_lead_star_nomatch: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.matched) |-> (results.status != ST_LEAD_STAR))
    else $error("match reported for pattern with leading star");

  // A processed transaction always shows up at the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> results.valid)
    else $error("processed transaction produced no result");

endmodule

`default_nettype wire

@@ rtl/rdsm_pattern_store.sv @@
// Pattern byte store with fill count, lead-star flag and the empty-text column,
// kept up to date on every append and reset by a clear. Depends on rdsm_pkg.
`default_nettype none

module rdsm_pattern_store
  import rdsm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      fire,
  input  wire cmd_t                                      cmd,
  input  wire logic [SYM_W-1:0]                          sym,
  output logic [MAX_PATTERN-1:0][SYM_W-1:0]              pattern,
  output logic [$clog2(MAX_PATTERN+1)-1:0]               count,
  output logic [$clog2(MAX_PATTERN+1)-1:0]               count_next,
  output logic [MAX_PATTERN:0]                           empty_next,
  output pat_flags_t                                     flags
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned AW = $clog2(MAX_PATTERN);

  logic                 lead_star;
  logic                 lead_star_next;
  logic [MAX_PATTERN:0] empty_col;
  logic [MAX_PATTERN:0] empty_add;
  logic                 full;
  logic                 append_ok;

  assign full      = (count == CW'(MAX_PATTERN));
  assign append_ok = (cmd == CMD_APPEND) && !full;

  // New empty-text bit at the appended position: a star repeats zero times
  always_comb begin
    empty_add = '0;
    for (int i = 2; i <= MAX_PATTERN; i++) begin
      if (count == CW'(i - 1)) begin
        empty_add[i] = (sym == SYM_STAR) && empty_col[i-2];
      end
    end
  end

  // Next count, lead flag and empty-text column
  always_comb begin
    count_next     = count;
    lead_star_next = lead_star;
    empty_next     = empty_col;
    unique case (cmd)
      CMD_CLEAR: begin
        count_next     = '0;
        lead_star_next = 1'b0;
        empty_next     = (MAX_PATTERN+1)'(1);
      end
      CMD_APPEND: begin
        if (append_ok) begin
          count_next = count + CW'(1);
          empty_next = empty_col | empty_add;
          if (count == '0) begin
            lead_star_next = (sym == SYM_STAR);
          end
        end
      end
      CMD_RESTART, CMD_TEXT: begin
        count_next = count;
      end
    endcase
  end

  assign flags.dropped   = (cmd == CMD_APPEND) && full;
  assign flags.lead_star = lead_star_next;

  // Advance control state on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      lead_star <= 1'b0;
      empty_col <= (MAX_PATTERN+1)'(1);
    end else if (fire) begin
      count     <= count_next;
      lead_star <= lead_star_next;
      empty_col <= empty_next;
    end
  end

  // Write the appended byte; entries are read only below the count
  always_ff @(posedge clk) begin
    if (fire && append_ok) begin
      pattern[count[AW-1:0]] <= sym;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rdsm_match_column.sv @@
// Match column register and its one-byte update: a parallel-prefix scan over
// the star recurrence, or a reload from the empty-text column. Depends on rdsm_pkg.
`default_nettype none

module rdsm_match_column
  import rdsm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  fire,
  input  wire cmd_t                                  cmd,
  input  wire logic [SYM_W-1:0]                      sym,
  input  wire logic [MAX_PATTERN-1:0][SYM_W-1:0]     pattern,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]      count,
  input  wire logic [MAX_PATTERN:0]                  empty_next,
  output logic [MAX_PATTERN:0]                       col_next
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN:0] col;
  logic [MAX_PATTERN:0] gen;
  logic [MAX_PATTERN:0] prop;
  logic [MAX_PATTERN:0] gen_acc;
  logic [MAX_PATTERN:0] prop_acc;
  logic [MAX_PATTERN:0] gen_tmp;
  logic [MAX_PATTERN:0] prop_tmp;

  // Per-position generate/propagate: a star takes the bit two back, or extends
  // its own bit when the element hits; a plain byte shifts the column by one
  always_comb begin
    gen  = '0;
    prop = '0;
    gen[1] = (pattern[0] != SYM_STAR) && elem_hits(pattern[0], sym) && col[0];
    for (int i = 2; i <= MAX_PATTERN; i++) begin
      if (pattern[i-1] == SYM_STAR) begin
        gen[i]  = elem_hits(pattern[i-2], sym) && col[i];
        prop[i] = 1'b1;
      end else begin
        gen[i]  = elem_hits(pattern[i-1], sym) && col[i-1];
      end
    end
    // Drop positions beyond the stored pattern
    for (int i = 1; i <= MAX_PATTERN; i++) begin
      if (CW'(i) > count) begin
        gen[i]  = 1'b0;
        prop[i] = 1'b0;
      end
    end
  end

  // Resolve bit(i) = gen(i) | prop(i) & bit(i-2) in log steps of doubling span
  always_comb begin
    gen_acc  = gen;
    prop_acc = prop;
    gen_tmp  = gen;
    prop_tmp = prop;
    for (int d = 2; d <= MAX_PATTERN; d = d * 2) begin
      gen_tmp  = gen_acc;
      prop_tmp = prop_acc;
      for (int i = d; i <= MAX_PATTERN; i++) begin
        gen_acc[i]  = gen_tmp[i] | (prop_tmp[i] & gen_tmp[i-d]);
        prop_acc[i] = prop_tmp[i] & prop_tmp[i-d];
      end
    end
  end

  assign col_next = (cmd == CMD_TEXT) ? gen_acc : empty_next;

  // Hold the column between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= (MAX_PATTERN+1)'(1);
    end else if (fire) begin
      col <= col_next;
    end
  end

endmodule

`default_nettype wire
